[rtl/core/lc3_pkg.sv]
// ----------------------------------------------------------------------------
// lc3_pkg
// shared types and constants of the lc-3 instruction step core
// ----------------------------------------------------------------------------
`default_nettype none

package lc3_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_READ_WAIT,
        ST_KB_STATUS,
        ST_KB_DATA,
        ST_DECODE,
        ST_EXEC,
        ST_ACCESS,
        ST_STORE,
        ST_TRAP_KEY,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        PH_FETCH,
        PH_ADDR,
        PH_IND
    } phase_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_AND,
        ALU_NOT,
        ALU_PASS
    } alu_op_t;

    localparam logic [3:0] OPC_BR   = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_LD   = 4'd2;
    localparam logic [3:0] OPC_ST   = 4'd3;
    localparam logic [3:0] OPC_JSR  = 4'd4;
    localparam logic [3:0] OPC_AND  = 4'd5;
    localparam logic [3:0] OPC_LDR  = 4'd6;
    localparam logic [3:0] OPC_STR  = 4'd7;
    localparam logic [3:0] OPC_NOT  = 4'd9;
    localparam logic [3:0] OPC_LDI  = 4'd10;
    localparam logic [3:0] OPC_STI  = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_LEA  = 4'd14;
    localparam logic [3:0] OPC_TRAP = 4'd15;

    localparam logic [7:0] VEC_GETC = 8'h20;
    localparam logic [7:0] VEC_OUT  = 8'h21;
    localparam logic [7:0] VEC_IN   = 8'h23;
    localparam logic [7:0] VEC_HALT = 8'h25;

    localparam logic [15:0] KBSR_ADDR   = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR   = 16'hFE02;
    localparam logic [15:0] KEY_FLAG    = 16'h8000;
    localparam logic [2:0]  FLAG_P      = 3'b001;
    localparam logic [2:0]  FLAG_Z      = 3'b010;
    localparam logic [2:0]  FLAG_N      = 3'b100;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'd0) begin
            f = FLAG_Z;
        end else if (v[15]) begin
            f = FLAG_N;
        end else begin
            f = FLAG_P;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lc3_alu.sv]
// ----------------------------------------------------------------------------
// lc3_alu
// shared 16-bit add / and / not / pass unit used by the sequencer steps
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_alu
    import lc3_pkg::*;
(
    input  wire logic [15:0] a,
    input  wire logic [15:0] b,
    input  wire alu_op_t     op,
    output logic      [15:0] y
);

    always_comb begin
        case (op)
            ALU_ADD:  y = a + b;
            ALU_AND:  y = a & b;
            ALU_NOT:  y = ~a;
            ALU_PASS: y = a;
            default:  y = a;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/lc3_instruction_step.sv]
// ----------------------------------------------------------------------------
// lc3_instruction_step
// lc-3 core with word memory, register file, pc and nzp flags
// ----------------------------------------------------------------------------
// load request: accept, then the memory write state and the result state (write, result)
// step request: fetch, decode, execute; loads and sti add reads, stores a write, getc/in
//   a key state, a keyboard status read one more; set by the single memory port and one shared alu
// one request at a time; s_tready is high only while the sequencer idles,
//   the next request is taken at the earliest in the cycle after the result handshake
// after reset a clearing pass zeroes each of the MEMORY_WORDS words in turn,
//   requests wait, configuration writes are taken
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_instruction_step
    import lc3_pkg::*;
#(
    parameter int MEMORY_WORDS = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // address, data, key_ready, key_char, zero pad
    input  wire logic        s_tuser,  // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata   // program_counter, char_valid, char_out,
                                       // trap_taken, trap_vector, r0_value,
                                       // halted, fault, zero pad
);

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_WORDS - 1);

    function automatic logic in_range(input logic [15:0] a);
        return {1'b0, a} < 17'(MEMORY_WORDS);
    endfunction

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [15:0] pc_reg, pc_next;
    logic [15:0] start_reg, start_next;
    logic [2:0]  flags_reg, flags_next;
    logic        halt_reg, halt_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] wdat_reg, wdat_next;
    logic [15:0] val_reg, val_next;
    logic [15:0] ir_reg, ir_next;
    logic [15:0] opa_reg, opa_next;
    logic        kr_reg, kr_next;
    logic [7:0]  kc_reg, kc_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        cv_reg, cv_next;
    logic [7:0]  co_reg, co_next;
    logic        tt_reg, tt_next;
    logic [7:0]  tv_reg, tv_next;
    logic        flt_reg, flt_next;

    logic [15:0] rf_reg [8];
    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;
    logic [2:0]  rf_raddr;
    logic [15:0] rf_rdata;

    logic [15:0] mem [MEMORY_WORDS];
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;
    logic [15:0] mem_rdata_reg;

    logic [15:0] alu_a, alu_b, alu_y;
    alu_op_t     alu_op;

    logic [3:0]  opc;
    logic [2:0]  dr, sr2;
    logic [15:0] off9, off6, off11, imm5;
    logic [15:0] key_status;
    logic        s_accept;

    lc3_alu u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    assign opc   = ir_reg[15:12];
    assign dr    = ir_reg[11:9];
    assign sr2   = ir_reg[2:0];
    assign off9  = {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign off6  = {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign off11 = {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign imm5  = {{11{ir_reg[4]}}, ir_reg[4:0]};
    assign key_status = kr_reg ? KEY_FLAG : 16'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESULT);
    assign s_accept = s_tvalid && s_tready;
    assign m_tdata  = {4'd0, flt_reg, halt_reg, rf_reg[0], tv_reg, tt_reg,
                       co_reg, cv_reg, pc_reg};

    always_comb begin
        case (state_reg)
            ST_DECODE: rf_raddr = val_reg[8:6];
            ST_EXEC:   rf_raddr = (opc == OPC_ADD || opc == OPC_AND) ? sr2 : dr;
            default:   rf_raddr = dr;
        endcase
    end
    assign rf_rdata = rf_reg[rf_raddr];

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        pc_next    = pc_reg;
        start_next = start_reg;
        flags_next = flags_reg;
        halt_next  = halt_reg;
        addr_next  = addr_reg;
        wdat_next  = wdat_reg;
        val_next   = val_reg;
        ir_next    = ir_reg;
        opa_next   = opa_reg;
        kr_next    = kr_reg;
        kc_next    = kc_reg;
        clr_next   = clr_reg;
        cv_next    = cv_reg;
        co_next    = co_reg;
        tt_next    = tt_reg;
        tv_next    = tv_reg;
        flt_next   = flt_reg;
        mem_we     = 1'b0;
        mem_addr   = addr_reg[AW-1:0];
        mem_wdata  = wdat_reg;
        rf_we      = 1'b0;
        rf_waddr   = dr;
        rf_wdata   = alu_y;
        alu_a      = pc_reg;
        alu_b      = off9;
        alu_op     = ALU_ADD;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 16'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    kr_next  = s_tdata[32];
                    kc_next  = s_tdata[40:33];
                    cv_next  = 1'b0;
                    co_next  = 8'd0;
                    tt_next  = 1'b0;
                    tv_next  = 8'd0;
                    flt_next = 1'b0;
                    if (!s_tuser) begin
                        addr_next  = s_tdata[15:0];
                        wdat_next  = s_tdata[31:16];
                        state_next = ST_LOAD;
                    end else if (halt_reg) begin
                        state_next = ST_RESULT;
                    end else begin
                        addr_next  = pc_reg;
                        phase_next = PH_FETCH;
                        state_next = ST_READ;
                    end
                end
            end
            ST_LOAD: begin
                mem_we     = in_range(addr_reg);
                state_next = ST_RESULT;
            end
            ST_READ: begin
                if (phase_reg == PH_FETCH) begin
                    alu_b   = 16'd1;
                    pc_next = alu_y;
                end
                state_next = (addr_reg == KBSR_ADDR) ? ST_KB_STATUS : ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                val_next   = in_range(addr_reg) ? mem_rdata_reg : 16'd0;
                state_next = (phase_reg == PH_FETCH) ? ST_DECODE : ST_ACCESS;
            end
            ST_KB_STATUS: begin
                mem_we     = in_range(KBSR_ADDR);
                mem_addr   = KBSR_ADDR[AW-1:0];
                mem_wdata  = key_status;
                state_next = ST_KB_DATA;
            end
            ST_KB_DATA: begin
                mem_we     = kr_reg && in_range(KBDR_ADDR);
                mem_addr   = KBDR_ADDR[AW-1:0];
                mem_wdata  = {8'd0, kc_reg};
                val_next   = key_status;
                state_next = (phase_reg == PH_FETCH) ? ST_DECODE : ST_ACCESS;
            end
            ST_DECODE: begin
                ir_next    = val_reg;
                opa_next   = rf_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_RESULT;
                case (opc)
                    OPC_ADD, OPC_AND: begin
                        alu_a      = opa_reg;
                        alu_b      = ir_reg[5] ? imm5 : rf_rdata;
                        alu_op     = (opc == OPC_ADD) ? ALU_ADD : ALU_AND;
                        rf_we      = 1'b1;
                        flags_next = flags_of(alu_y);
                    end
                    OPC_NOT: begin
                        alu_a      = opa_reg;
                        alu_op     = ALU_NOT;
                        rf_we      = 1'b1;
                        flags_next = flags_of(alu_y);
                    end
                    OPC_BR: begin
                        if ((flags_reg & dr) != 3'd0) begin
                            pc_next = alu_y;
                        end
                    end
                    OPC_JMP: begin
                        pc_next = opa_reg;
                    end
                    OPC_JSR: begin
                        alu_b    = off11;
                        rf_we    = 1'b1;
                        rf_waddr = 3'd7;
                        rf_wdata = pc_reg;
                        pc_next  = ir_reg[11] ? alu_y : opa_reg;
                    end
                    OPC_LD, OPC_LDI, OPC_STI: begin
                        addr_next  = alu_y;
                        phase_next = PH_ADDR;
                        state_next = ST_READ;
                    end
                    OPC_LDR: begin
                        alu_a      = opa_reg;
                        alu_b      = off6;
                        addr_next  = alu_y;
                        phase_next = PH_ADDR;
                        state_next = ST_READ;
                    end
                    OPC_ST: begin
                        addr_next  = alu_y;
                        state_next = ST_STORE;
                    end
                    OPC_STR: begin
                        alu_a      = opa_reg;
                        alu_b      = off6;
                        addr_next  = alu_y;
                        state_next = ST_STORE;
                    end
                    OPC_LEA: begin
                        rf_we      = 1'b1;
                        flags_next = flags_of(alu_y);
                    end
                    OPC_TRAP: begin
                        tt_next  = 1'b1;
                        tv_next  = ir_reg[7:0];
                        rf_we    = 1'b1;
                        rf_waddr = 3'd7;
                        rf_wdata = pc_reg;
                        if (ir_reg[7:0] == VEC_GETC || ir_reg[7:0] == VEC_IN) begin
                            state_next = ST_TRAP_KEY;
                        end else if (ir_reg[7:0] == VEC_OUT) begin
                            cv_next = 1'b1;
                            co_next = rf_reg[0][7:0];
                        end else if (ir_reg[7:0] == VEC_HALT) begin
                            halt_next = 1'b1;
                        end
                    end
                    default: begin
                        flt_next = 1'b1;
                    end
                endcase
            end
            ST_ACCESS: begin
                if (opc == OPC_LDI && phase_reg == PH_ADDR) begin
                    addr_next  = val_reg;
                    phase_next = PH_IND;
                    state_next = ST_READ;
                end else if (opc == OPC_STI) begin
                    addr_next  = val_reg;
                    state_next = ST_STORE;
                end else begin
                    rf_we      = 1'b1;
                    rf_wdata   = val_reg;
                    flags_next = flags_of(val_reg);
                    state_next = ST_RESULT;
                end
            end
            ST_STORE: begin
                mem_we     = in_range(addr_reg);
                mem_wdata  = rf_rdata;
                state_next = ST_RESULT;
            end
            ST_TRAP_KEY: begin
                rf_we      = 1'b1;
                rf_waddr   = 3'd0;
                rf_wdata   = {8'd0, kc_reg};
                flags_next = flags_of({8'd0, kc_reg});
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wen) begin
            start_next = cfg_wdata;
            pc_next    = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FETCH;
            start_reg <= 16'h3000;
            pc_reg    <= 16'h3000;
            flags_reg <= FLAG_Z;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
            for (int i = 0; i < 8; i++) begin
                rf_reg[i] <= 16'd0;
            end
        end else begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            pc_reg    <= pc_next;
            flags_reg <= flags_next;
            halt_reg  <= halt_next;
            clr_reg   <= clr_next;
            if (rf_we) begin
                rf_reg[rf_waddr] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        wdat_reg <= wdat_next;
        val_reg  <= val_next;
        ir_reg   <= ir_next;
        opa_reg  <= opa_next;
        kr_reg   <= kr_next;
        kc_reg   <= kc_next;
        cv_reg   <= cv_next;
        co_reg   <= co_next;
        tt_reg   <= tt_next;
        tv_reg   <= tv_next;
        flt_reg  <= flt_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

endmodule

`default_nettype wire

[rtl/core/lc3_step_checker.sv]
// ----------------------------------------------------------------------------
// lc3_step_checker
// port-level checks of the lc-3 instruction step core, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module lc3_step_checker
    import lc3_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    // result held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // one request in flight
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("request accepted while result pending");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tdata[50] |=> m_tdata[50])
        else $error("halted cleared without reset");

    // character only from an out trap
    a_char_out_trap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[25] && m_tdata[33:26] == VEC_OUT)
        else $error("character without out trap");

    // fault excludes trap
    a_fault_no_trap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[51] |-> !m_tdata[25] && !m_tdata[16])
        else $error("fault together with trap");

endmodule

bind lc3_instruction_step lc3_step_checker u_lc3_step_checker (.*);

`default_nettype wire

[dv/lc3_instruction_step_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lc3_instruction_step_test
// Drives memory loads and single-instruction steps into the LC-3 core and
// checks every result against an in-bench instruction-set predictor. Random
// programs are written just ahead of the predicted PC, so most steps run
// freshly generated instructions, over several start addresses and under
// varying sender and receiver stalls.
// ----------------------------------------------------------------------------
module lc3_instruction_step_test;
    import lc3_pkg::*;

    localparam int QUIET_LIMIT = 200000;
    localparam int SETTLE = 24;

    typedef struct packed {
        bit [3:0]  pad;
        bit        fault;
        bit        halted;
        bit [15:0] r0_value;
        bit [7:0]  trap_vector;
        bit        trap_taken;
        bit [7:0]  char_out;
        bit        char_valid;
        bit [15:0] program_counter;
    } core_status_t;

    class lc3_scoreboard;
        bit [15:0] mem [65536];
        bit [15:0] regs [8];
        bit [15:0] pc;
        bit [2:0]  cc;
        bit        halt;
        core_status_t expected_status [$];
        int errors;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (regs[i]) regs[i] = '0;
            pc = 16'h3000;
            cc = FLAG_Z;
            halt = 0;
            errors = 0;
        endfunction

        function void set_start(bit [15:0] v);
            pc = v;
        endfunction

        function bit [15:0] sx(bit [15:0] v, int n);
            bit [15:0] m;
            m = 16'(1 << (n - 1));
            v = v & 16'((1 << n) - 1);
            return (v ^ m) - m;
        endfunction

        function void setcc(bit [15:0] v);
            cc = (v == 0) ? FLAG_Z : (v[15] ? FLAG_N : FLAG_P);
        endfunction

        function bit [15:0] read_word(bit [15:0] a, bit kr, bit [7:0] kc);
            if (a == KBSR_ADDR) begin
                mem[KBSR_ADDR] = kr ? KEY_FLAG : 16'h0;
                if (kr) mem[KBDR_ADDR] = {8'h0, kc};
            end
            return mem[a];
        endfunction

        function void note_request(bit op, bit [15:0] addr, bit [15:0] data,
                                   bit kr, bit [7:0] kc);
            core_status_t r;
            bit [15:0] ir, b;
            bit [2:0] dr, s1;
            r = '0;
            if (!op) begin
                mem[addr] = data;
            end else if (!halt) begin
                ir = read_word(pc, kr, kc);
                dr = ir[11:9];
                s1 = ir[8:6];
                pc = pc + 1;
                case (ir[15:12])
                    OPC_ADD, OPC_AND: begin
                        b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
                        regs[dr] = (ir[15:12] == OPC_ADD) ? regs[s1] + b : regs[s1] & b;
                        setcc(regs[dr]);
                    end
                    OPC_NOT: begin
                        regs[dr] = ~regs[s1];
                        setcc(regs[dr]);
                    end
                    OPC_BR: if ((cc & dr) != 0) pc = pc + sx(ir, 9);
                    OPC_JMP: pc = regs[s1];
                    OPC_JSR: begin
                        b = ir[11] ? pc + sx(ir, 11) : regs[s1];
                        regs[7] = pc;
                        pc = b;
                    end
                    OPC_LD: begin
                        regs[dr] = read_word(pc + sx(ir, 9), kr, kc);
                        setcc(regs[dr]);
                    end
                    OPC_LDI: begin
                        b = read_word(pc + sx(ir, 9), kr, kc);
                        regs[dr] = read_word(b, kr, kc);
                        setcc(regs[dr]);
                    end
                    OPC_LDR: begin
                        regs[dr] = read_word(regs[s1] + sx(ir, 6), kr, kc);
                        setcc(regs[dr]);
                    end
                    OPC_LEA: begin
                        regs[dr] = pc + sx(ir, 9);
                        setcc(regs[dr]);
                    end
                    OPC_ST: mem[pc + sx(ir, 9)] = regs[dr];
                    OPC_STI: begin
                        b = read_word(pc + sx(ir, 9), kr, kc);
                        mem[b] = regs[dr];
                    end
                    OPC_STR: mem[regs[s1] + sx(ir, 6)] = regs[dr];
                    OPC_TRAP: begin
                        r.trap_taken = 1;
                        r.trap_vector = ir[7:0];
                        regs[7] = pc;
                        if (ir[7:0] == VEC_GETC || ir[7:0] == VEC_IN) begin
                            regs[0] = {8'h0, kc};
                            setcc(regs[0]);
                        end else if (ir[7:0] == VEC_OUT) begin
                            r.char_valid = 1;
                            r.char_out = regs[0][7:0];
                        end else if (ir[7:0] == VEC_HALT) begin
                            halt = 1;
                        end
                    end
                    default: r.fault = 1;
                endcase
            end
            r.program_counter = pc;
            r.r0_value = regs[0];
            r.halted = halt;
            expected_status.push_back(r);
        endfunction

        function void cmp(string name, bit [15:0] e, bit [15:0] a);
            if (e != a) begin
                errors++;
                $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
            end
        endfunction

        function void check_result(bit [55:0] raw);
            core_status_t a, e;
            a = raw;
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, raw);
                return;
            end
            e = expected_status.pop_front();
            cmp("program_counter", e.program_counter, a.program_counter);
            cmp("char_valid", e.char_valid, a.char_valid);
            cmp("char_out", e.char_out, a.char_out);
            cmp("trap_taken", e.trap_taken, a.trap_taken);
            cmp("trap_vector", e.trap_vector, a.trap_vector);
            cmp("r0_value", e.r0_value, a.r0_value);
            cmp("halted", e.halted, a.halted);
            cmp("fault", e.fault, a.fault);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wen = 0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;

    lc3_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;

    lc3_instruction_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("lc3_instruction_step_test: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send(bit op, bit [15:0] addr, bit [15:0] data);
        bit kr;
        bit [7:0] kc;
        kr = $urandom_range(1);
        kc = $urandom;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {7'd0, kc, kr, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, addr, data, kr, kc);
    endtask

    task automatic run_word(bit [15:0] ir);
        send(0, sb.pc, ir);
        send(1, $urandom, $urandom);
    endtask

    task automatic write_start(bit [15:0] v);
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wen <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 0;
        sb.set_start(v);
    endtask

    function automatic bit [15:0] no_halt(bit [15:0] w);
        if (w[15:12] == OPC_TRAP && w[7:0] == VEC_HALT) w[7:0] = VEC_OUT;
        return w;
    endfunction

    function automatic bit [15:0] rand_instr();
        bit [15:0] w;
        w = $urandom;
        if ($urandom_range(99) < 12) w[15:12] = OPC_TRAP;
        if (w[15:12] == OPC_TRAP && $urandom_range(1)) w[7:0] = 8'h20 + $urandom_range(4);
        return no_halt(w);
    endfunction

    task automatic random_phase(int n);
        int k;
        bit [15:0] d;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: run_word(rand_instr());
                6: begin
                    case ($urandom_range(3))
                        0: d = KBSR_ADDR;
                        1: d = KBDR_ADDR;
                        default: d = no_halt($urandom);
                    endcase
                    send(0, sb.pc + 16'($signed($urandom_range(16)) - 8), d);
                end
                7: send(0, $urandom, no_halt($urandom));
                default: send(1, $urandom, $urandom);
            endcase
        end
    endtask

    initial begin
        bit [15:0] directed [] = '{
            16'h127F, 16'h546F, 16'h1642, 16'h9840, 16'h0E01, 16'hE100, 16'hE0FF,
            16'h2BFF, 16'hA000, 16'h6FBF, 16'h3E00, 16'hB000, 16'h7000, 16'h4FFF,
            16'h41C0, 16'hC1C0, 16'hD000, 16'h8000, 16'hF020, 16'hF021, 16'hF022,
            16'hF023, 16'hF024, 16'hF0FF
        };
        bit [15:0] starts [] = '{16'h0000, 16'hFFFF, 16'hFE00, 16'h3000};
        int idles [3][2] = '{'{35, 62}, '{62, 35}, '{0, 0}};
        int m, p;

        repeat (8) @(posedge aclk);
        aresetn <= 1;
        write_start(16'h3000);
        send(0, 16'hFFFF, 16'hFFFF);
        send(0, 16'h0000, 16'h0000);
        foreach (directed[i]) run_word(directed[i]);

        for (m = 0; m < 3; m++) begin
            send_idle = idles[m][0];
            recv_idle = idles[m][1];
            for (p = 0; p < 4; p++) begin
                write_start((p == 3) ? 16'($urandom) : starts[(m + p) % 4]);
                random_phase(100);
            end
        end

        run_word({OPC_TRAP, 4'h0, VEC_HALT});
        send(1, $urandom, $urandom);
        send(0, $urandom, $urandom);
        send(1, $urandom, $urandom);
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("lc3_instruction_step_test: clean");
        end else begin
            $display("lc3_instruction_step_test: errors");
        end
        $finish;
    end
endmodule
